FILE: hw/rtl/swmo_pkg.sv
// Shared constants, token type and length helper for the sliding-window minimum offset unit.
`timescale 1ns / 1ps
`default_nettype none

package swmo_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int SAMPLE_W   = 32;
    localparam int LEN_W      = 7;
    localparam int OFF_W      = 6;

    // Largest sample value; seeds the minimum search in the first cell.
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET = LEN_W'(14);

    // Running-minimum token that walks the cell chain.
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] val;
        logic [OFF_W-1:0]           off;
    } tok_t;

    // Zero acts as one, anything above the store depth is clamped to it.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] w);
        logic [LEN_W-1:0] r;
        begin
            r = w;
            if (w == '0)
                r = LEN_W'(1);
            else if (w > LEN_W'(MAX_WINDOW))
                r = LEN_W'(MAX_WINDOW);
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sliding_window_min_offset_unit.sv
// Top level of the sliding-window minimum offset unit: cell chain, control and output buffer.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted sample beat enters a chain of 64 cells that holds the most
// recent samples, newest in cell 0. Once as many samples have arrived as the
// effective window length (window_length, zero read as one, clamped to 64),
// every sample beat yields one min_offset beat: how many samples back the
// window minimum lies, 0 being the sample just taken, ties going to the newer
// sample. Before the window is full a sample beat gives no result and the
// unit is ready again in the next cycle. For a beat that does give a result,
// a minimum token walks the chain one cell per cycle, from cell 0 to the last
// cell of the window (cell L - 1, L being the effective length), and the
// result is registered into the output buffer as it leaves that cell; only
// then is the next sample taken. A two-entry output buffer lets the next
// search start while a finished result still waits for out_ready.
// window_length is written through its own channel (always ready) and must
// only change while the unit is idle; the stored samples and fill count are
// kept across a change. Reset length is 14.
module sliding_window_min_offset_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output      logic                                 cfg_ready,
    input  wire logic [swmo_pkg::LEN_W-1:0]           window_length,
    input  wire logic                                 in_valid,
    output      logic                                 in_ready,
    input  wire logic signed [swmo_pkg::SAMPLE_W-1:0] sample,
    output      logic                                 out_valid,
    input  wire logic                                 out_ready,
    output      logic [swmo_pkg::OFF_W-1:0]           min_offset
);

    localparam int N = swmo_pkg::MAX_WINDOW;

    logic [swmo_pkg::LEN_W-1:0] wl_reg;
    logic [swmo_pkg::LEN_W-1:0] fill_reg;
    logic [swmo_pkg::LEN_W-1:0] fill_next;
    logic [swmo_pkg::LEN_W-1:0] len_reg;
    logic [swmo_pkg::LEN_W-1:0] len_now;
    logic                       launch_reg;
    logic                       search_reg;
    logic                       search_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [swmo_pkg::OFF_W-1:0] min_offset_reg;
    logic [swmo_pkg::OFF_W-1:0] min_offset_next;
    logic                       skid_valid_reg;
    logic                       skid_valid_next;
    logic [swmo_pkg::OFF_W-1:0] skid_off_reg;
    logic [swmo_pkg::OFF_W-1:0] skid_off_next;

    logic                       in_take;
    logic                       out_take;
    logic                       has_result;

    logic signed [swmo_pkg::SAMPLE_W-1:0] store [N];
    swmo_pkg::tok_t                       tok_in  [N];
    swmo_pkg::tok_t                       tok_out [N];
    logic [N-1:0]                         last;
    logic [N-1:0]                         fin_vec;
    logic                                 fin;
    logic [swmo_pkg::OFF_W-1:0]           fin_off;

    assign cfg_ready = 1'b1;
    assign in_ready  = !search_reg && !skid_valid_reg;
    assign in_take   = in_valid && in_ready;
    assign out_take  = out_valid_reg && out_ready;

    // Saturating fill count and the length that applies to this beat.
    assign fill_next  = (fill_reg == swmo_pkg::LEN_W'(N)) ? fill_reg
                                                          : fill_reg + swmo_pkg::LEN_W'(1);
    assign len_now    = swmo_pkg::eff_len(wl_reg);
    assign has_result = (fill_next >= len_now);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wl_reg <= swmo_pkg::WINDOW_LENGTH_RESET;
        else if (cfg_valid && cfg_ready)
            wl_reg <= window_length;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            len_reg    <= swmo_pkg::LEN_W'(1);
            launch_reg <= 1'b0;
        end
        else
        begin
            launch_reg <= in_take && has_result;
            if (in_take)
            begin
                fill_reg <= fill_next;
                len_reg  <= len_now;
            end
        end
    end

    // Search stays open from the sample beat until the token leaves the last cell.
    always_comb
    begin
        search_next = search_reg;
        if (fin)
            search_next = 1'b0;
        if (in_take && has_result)
            search_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            search_reg <= 1'b0;
        else
            search_reg <= search_next;
    end

    // Seed token: the first cell always takes its own sample as the best so far.
    assign tok_in[0].valid = launch_reg;
    assign tok_in[0].val   = swmo_pkg::SAMPLE_MAX;
    assign tok_in[0].off   = '0;

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_cell
            // mark the cell at the far end of the window
            assign last[k]    = (len_reg == swmo_pkg::LEN_W'(k + 1));
            assign fin_vec[k] = tok_out[k].valid && last[k];

            if (k > 0)
            begin : g_link
                // drop the token once it has passed the window's end
                assign tok_in[k].valid = tok_out[k-1].valid && !last[k-1];
                assign tok_in[k].val   = tok_out[k-1].val;
                assign tok_in[k].off   = tok_out[k-1].off;
            end

            swmo_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift_en  (in_take),
                .shift_in  ((k == 0) ? sample : store[(k > 0) ? k - 1 : 0]),
                .store_out (store[k]),
                .cell_idx  (swmo_pkg::OFF_W'(k)),
                .tok_in    (tok_in[k]),
                .tok_out   (tok_out[k])
            );
        end
    endgenerate

    // At most one token is in flight, so an OR picks its offset.
    assign fin = |fin_vec;

    always_comb
    begin
        fin_off = '0;
        for (int i = 0; i < N; i++)
        begin
            if (fin_vec[i])
                fin_off = fin_off | tok_out[i].off;
        end
    end

    // Output register plus one skid entry.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        min_offset_next = min_offset_reg;
        skid_valid_next = skid_valid_reg;
        skid_off_next   = skid_off_reg;
        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                min_offset_next = skid_off_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (fin)
        begin
            if (!out_valid_next)
            begin
                out_valid_next  = 1'b1;
                min_offset_next = fin_off;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_off_next   = fin_off;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_offset_reg <= min_offset_next;
        skid_off_reg   <= skid_off_next;
    end

    assign out_valid  = out_valid_reg;
    assign min_offset = min_offset_reg;

    // Only one cell may finish a search in a given cycle.
    a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(fin_vec))
        else $error("more than one cell finished a search");

    // A token can only finish while a search is open.
    a_fin_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> search_reg)
        else $error("search finished with no search open");

    // The skid entry is only used behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a result with the output register empty");

    // A found offset always lies inside the window.
    a_off_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> ({1'b0, fin_off} < len_reg))
        else $error("minimum offset outside the window");

endmodule

`default_nettype wire

FILE: hw/rtl/swmo_cell.sv
// One cell of the window chain: holds one sample and updates the passing minimum token.
`timescale 1ns / 1ps
`default_nettype none

module swmo_cell (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     shift_en,
    input  wire logic signed [swmo_pkg::SAMPLE_W-1:0]     shift_in,
    output      logic signed [swmo_pkg::SAMPLE_W-1:0]     store_out,
    input  wire logic [swmo_pkg::OFF_W-1:0]               cell_idx,
    input  wire swmo_pkg::tok_t                           tok_in,
    output      swmo_pkg::tok_t                           tok_out
);

    logic signed [swmo_pkg::SAMPLE_W-1:0] store_reg;
    logic                                 tok_valid_reg;
    logic                                 tok_valid_next;
    logic signed [swmo_pkg::SAMPLE_W-1:0] tok_val_reg;
    logic signed [swmo_pkg::SAMPLE_W-1:0] tok_val_next;
    logic [swmo_pkg::OFF_W-1:0]           tok_off_reg;
    logic [swmo_pkg::OFF_W-1:0]           tok_off_next;

    // advance the sample one place down the window
    always_ff @(posedge clk)
    begin
        if (shift_en)
            store_reg <= shift_in;
    end

    // an older sample wins only if strictly smaller
    always_comb
    begin
        tok_valid_next = tok_in.valid;
        tok_val_next   = tok_in.val;
        tok_off_next   = tok_in.off;
        if (store_reg < tok_in.val)
        begin
            tok_val_next = store_reg;
            tok_off_next = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else
            tok_valid_reg <= tok_valid_next;
    end

    always_ff @(posedge clk)
    begin
        tok_val_reg <= tok_val_next;
        tok_off_reg <= tok_off_next;
    end

    assign store_out     = store_reg;
    assign tok_out.valid = tok_valid_reg;
    assign tok_out.val   = tok_val_reg;
    assign tok_out.off   = tok_off_reg;

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the sliding-window minimum offset unit.
`timescale 1ns / 1ps

// Sample beats go in through a valid/ready channel. A local predictor keeps
// its own history of the most recent samples and works out the offset of the
// window minimum, newest first, with ties going to the newer sample. Each
// min_offset beat is checked against the oldest prediction still waiting.
// The window length register is rewritten between phases, only once the unit
// is idle. Phases cover the fill-up after reset, zero and oversized lengths,
// length changes with the history kept, a drain pause, and a full-rate tail.
module tb;

    localparam int CYCLE_LIMIT   = 500000;
    // Longest search walk through the cell chain, plus margin.
    localparam int SETTLE_CYCLES = swmo_pkg::MAX_WINDOW + 8;

    localparam logic signed [swmo_pkg::SAMPLE_W-1:0] SAMPLE_MIN =
        {1'b1, {(swmo_pkg::SAMPLE_W-1){1'b0}}};

    // Shapes of the random sample runs.
    typedef enum int {
        SRC_RANDOM,
        SRC_TIES,
        SRC_EXTREME,
        SRC_RISING,
        SRC_FALLING
    } src_mode_t;

    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 cfg_valid     = 1'b0;
    logic                                 cfg_ready;
    logic [swmo_pkg::LEN_W-1:0]           window_length = swmo_pkg::WINDOW_LENGTH_RESET;
    logic                                 in_valid      = 1'b0;
    logic                                 in_ready;
    logic signed [swmo_pkg::SAMPLE_W-1:0] sample        = '0;
    logic                                 out_valid;
    logic                                 out_ready     = 1'b0;
    logic [swmo_pkg::OFF_W-1:0]           min_offset;

    // Predictor state: sample history, write slot, fill level, current length.
    logic signed [swmo_pkg::SAMPLE_W-1:0] sample_hist [swmo_pkg::MAX_WINDOW];
    int                                   hist_wr   = 0;
    int                                   hist_fill = 0;
    logic [swmo_pkg::LEN_W-1:0]           win_len   = swmo_pkg::WINDOW_LENGTH_RESET;

    // Predicted offsets, oldest first.
    logic [swmo_pkg::OFF_W-1:0] expected_offsets [$];

    int    items_sent   = 0;
    int    results_seen = 0;
    int    errors       = 0;
    int    cycle_count  = 0;
    bit    idle_bursts  = 1'b1;
    int    stall_left   = 0;
    string lengths_seen = "";

    // Random source state.
    src_mode_t src_mode     = SRC_RANDOM;
    int        src_run_left = 0;
    int        ramp_val     = 0;

    sliding_window_min_offset_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_length (window_length),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .min_offset    (min_offset)
    );

    always #5 clk = ~clk;

    // Store one sample in the history and, once the window is full, return
    // the offset of its minimum. An older sample wins only if strictly smaller.
    function automatic bit predict_argmin(input logic signed [swmo_pkg::SAMPLE_W-1:0] s,
                                          output logic [swmo_pkg::OFF_W-1:0] off);
        int                                   newest;
        int                                   span;
        int                                   idx;
        int                                   k;
        logic signed [swmo_pkg::SAMPLE_W-1:0] best;
        newest = hist_wr;
        sample_hist[newest] = s;
        hist_wr = (newest + 1) % swmo_pkg::MAX_WINDOW;
        if (hist_fill < swmo_pkg::MAX_WINDOW)
            hist_fill++;
        // Zero reads as one, anything above the store depth is clamped.
        if (win_len == '0)
            span = 1;
        else if (win_len > swmo_pkg::LEN_W'(swmo_pkg::MAX_WINDOW))
            span = swmo_pkg::MAX_WINDOW;
        else
            span = int'(win_len);
        off = '0;
        if (hist_fill < span)
            return 1'b0;
        best = s;
        for (k = 1; k < span; k++)
        begin
            idx = (newest - k + swmo_pkg::MAX_WINDOW) % swmo_pkg::MAX_WINDOW;
            if (sample_hist[idx] < best)
            begin
                best = sample_hist[idx];
                off  = swmo_pkg::OFF_W'(k);
            end
        end
        return 1'b1;
    endfunction

    // Draw the next random sample. Runs of one shape give ties, extremes and
    // monotone ramps that push the minimum to either end of the window.
    function automatic logic signed [swmo_pkg::SAMPLE_W-1:0] next_sample();
        int pick;
        logic signed [swmo_pkg::SAMPLE_W-1:0] v;
        if (src_run_left == 0)
        begin
            pick         = $urandom_range(0, 7);
            src_mode     = (pick > 4) ? SRC_RANDOM : src_mode_t'(pick);
            src_run_left = $urandom_range(1, 80);
            ramp_val     = int'($urandom_range(0, 2000)) - 1000;
        end
        src_run_left--;
        case (src_mode)
            SRC_TIES:
                v = int'($urandom_range(0, 6)) - 3;
            SRC_EXTREME:
                case ($urandom_range(0, 5))
                    0:       v = SAMPLE_MIN;
                    1:       v = swmo_pkg::SAMPLE_MAX;
                    2:       v = SAMPLE_MIN + 1;
                    3:       v = swmo_pkg::SAMPLE_MAX - 1;
                    4:       v = -1;
                    default: v = '0;
                endcase
            SRC_RISING:
            begin
                ramp_val = ramp_val + int'($urandom_range(0, 50));
                v = ramp_val;
            end
            SRC_FALLING:
            begin
                ramp_val = ramp_val - int'($urandom_range(0, 50));
                v = ramp_val;
            end
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Offer one sample beat, after an optional idle burst, and hold it until
    // accepted. valid stays high on return so back-to-back beats need no gap.
    task automatic send_sample(input logic signed [swmo_pkg::SAMPLE_W-1:0] v);
        logic [swmo_pkg::OFF_W-1:0] off;
        int                         gap;
        if (idle_bursts && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (predict_argmin(v, off))
            expected_offsets.push_back(off);
    endtask

    // Drop valid and hold until every predicted result has been seen.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (expected_offsets.size() != 0)
            @(posedge clk);
    endtask

    // Write the window length once the unit has gone idle. With every result
    // back the last search is over; hold a few more cycles for margin.
    task automatic set_window_length(input logic [swmo_pkg::LEN_W-1:0] len);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid     <= 1'b1;
        window_length <= len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        win_len = len;
        lengths_seen = {lengths_seen, $sformatf(" %0d", len)};
    endtask

    // Fill-up after reset at the reset length: extremes and ties, with no
    // result until the fourteenth beat.
    task automatic test_fill_from_reset();
        logic signed [swmo_pkg::SAMPLE_W-1:0] seq [16];
        seq = '{swmo_pkg::SAMPLE_MAX, SAMPLE_MIN, 0, -1, 1, SAMPLE_MIN, 7, 7,
                7, -1, swmo_pkg::SAMPLE_MAX, 0, 3, 3, SAMPLE_MIN, swmo_pkg::SAMPLE_MAX};
        foreach (seq[i])
            send_sample(seq[i]);
    endtask

    // Zero length acts as one, then one and two, with a tie in the pair.
    // The history is kept, so results come at once after each change.
    task automatic test_length_extremes();
        set_window_length(swmo_pkg::LEN_W'(0));
        send_sample(swmo_pkg::SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(0);
        set_window_length(swmo_pkg::LEN_W'(1));
        send_sample(-1);
        send_sample(1);
        set_window_length(swmo_pkg::LEN_W'(2));
        send_sample(9);
        send_sample(9);
        send_sample(8);
        send_sample(9);
    endtask

    // Random phases over several lengths: an oversized one is clamped to the
    // full depth, which reaches the oldest offset once the history fills. Some
    // phases run without idle bursts.
    task automatic test_random_lengths();
        logic [swmo_pkg::LEN_W-1:0] fixed_len [8];
        logic [swmo_pkg::LEN_W-1:0] len;
        int                         p;
        fixed_len = '{swmo_pkg::LEN_W'(127), swmo_pkg::LEN_W'(3), swmo_pkg::LEN_W'(64),
                      swmo_pkg::LEN_W'(2), swmo_pkg::LEN_W'(65), swmo_pkg::LEN_W'(0),
                      swmo_pkg::LEN_W'(9), swmo_pkg::LEN_W'(33)};
        for (p = 0; p < 10; p++)
        begin
            len = (p < 8) ? fixed_len[p] : swmo_pkg::LEN_W'($urandom_range(1, 127));
            set_window_length(len);
            idle_bursts = (p % 3 != 2);
            repeat (95) send_sample(next_sample());
        end
    endtask

    // Hold the sender mid-stream until every result is back, then resume.
    task automatic test_pause_until_drained();
        idle_bursts = 1'b1;
        set_window_length(swmo_pkg::LEN_W'(6));
        repeat (40) send_sample(next_sample());
        wait_results_drained();
        repeat (40) send_sample(next_sample());
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_full_rate();
        idle_bursts = 1'b0;
        set_window_length(swmo_pkg::LEN_W'(4));
        repeat (100) send_sample(next_sample());
    endtask

    // Receiver: drop ready in bursts of random length while idle bursts are on.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_bursts && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Check each accepted min_offset beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_offsets.size() == 0)
                report_mismatch("min_offset beat with no sample pending", min_offset, 0);
            else
            begin
                if (min_offset !== expected_offsets[0])
                    report_mismatch("min_offset", min_offset, expected_offsets[0]);
                void'(expected_offsets.pop_front());
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[%0t] timeout with %0d results outstanding", $time,
                     expected_offsets.size());
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_from_reset();
        test_length_extremes();
        test_random_lengths();
        test_pause_until_drained();
        test_full_rate();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d sample beats and %0d min_offset beats", items_sent,
                 results_seen);
        $display("Window lengths written:%s; mismatches: %0d", lengths_seen, errors);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
